@@ rtl/bpps_pkg.sv @@
// Shared types and constants of the Blinn-Phong point light shader.
package bpps_pkg;

    // Color channel width (Q0.CH_W) and derived output width (Q2.CH_W).
    localparam int CH_W    = 16;
    localparam int OUT_W   = CH_W + 2;
    localparam int REG_W   = 48;
    localparam int POS_W   = 16;

    // Vector components entering the normalizer: wide enough for L + V.
    localparam int COMP_W  = 19;

    // Fraction width of the Q1.16 dot/power word (1.0 = 1 << FRAC_W) and that word's width.
    localparam int FRAC_W  = 16;
    localparam int DOT_W   = FRAC_W + 1;

    // Depth of each normalizer pipeline, from a vector at its input to its unit vector.
    localparam int NORM_LAT = 53;

    // Configuration register indexes.
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] CFG_LIGHT_AMBIENT   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_LIGHT_DIFFUSE   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_LIGHT_SPECULAR  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_LIGHT_POSITION  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_CAMERA_POSITION = 3'd4;

    typedef logic signed [COMP_W-1:0] comp_t;
    typedef comp_t [2:0] vec_t;

endpackage

@@ rtl/blinn_phong_point_light_shader_unit.sv @@
// Throughput: one item per cycle; the whole pipeline advances together and
// holds while a finished result waits on m_tready, so a stall loses nothing.
// The four square roots and twelve divides are bit-serial, one bit per stage.
// Reset (rst_n low, asynchronous) empties the pipeline and clears every
// light and camera register to zero.
module blinn_phong_point_light_shader_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Input item: point_x, point_y, point_z, normal_x, normal_y, normal_z,
    // mat_ambient, mat_diffuse, mat_specular, shininess (lowest bits first).
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [247:0]                          s_tdata,
    // Result item: color_red, color_green, color_blue, saturated, one zero pad bit.
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [55:0]                           m_tdata,
    // Configuration write port.
    input  logic                                  cfg_we,
    input  logic [bpps_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [bpps_pkg::REG_W-1:0]            cfg_wdata
);

    localparam int CH_W   = bpps_pkg::CH_W;
    localparam int OUT_W  = bpps_pkg::OUT_W;
    localparam int REG_W  = bpps_pkg::REG_W;
    localparam int POS_W  = bpps_pkg::POS_W;
    localparam int COMP_W = bpps_pkg::COMP_W;
    localparam int FRAC_W = bpps_pkg::FRAC_W;
    localparam int DOT_W  = bpps_pkg::DOT_W;
    localparam int NL     = bpps_pkg::NORM_LAT;
    localparam int PROD_W = 2 * COMP_W;
    localparam int DSUM_W = PROD_W + 2;
    localparam int SH_W   = 8;
    localparam logic [DOT_W-1:0] ONE = DOT_W'(1) << FRAC_W;
    localparam logic [OUT_W:0]   OUT_MAX = {1'b0, {OUT_W{1'b1}}};

    typedef struct packed {
        logic [REG_W-1:0] mat_a;
        logic [REG_W-1:0] mat_d;
        logic [REG_W-1:0] mat_s;
        logic [SH_W-1:0]  shin;
    } side_t;

    typedef struct packed {
        side_t          side;
        bpps_pkg::vec_t n;
        bpps_pkg::vec_t l;
    } side_b_t;

    typedef struct packed {
        logic [DOT_W-1:0]      p;
        logic [DOT_W-1:0]      b;
        logic [DOT_W-1:0]      ndl;
        logic                  pos;
        logic [2:0][CH_W-1:0]  ka;
        logic [2:0][CH_W-1:0]  kd;
        logic [2:0][CH_W-1:0]  ks;
        logic [SH_W-1:0]       shin;
    } pw_t;

    // Configuration registers.
    logic [REG_W-1:0] light_amb_reg;
    logic [REG_W-1:0] light_dif_reg;
    logic [REG_W-1:0] light_spc_reg;
    logic [REG_W-1:0] light_pos_reg;
    logic [REG_W-1:0] cam_pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_amb_reg <= '0;
            light_dif_reg <= '0;
            light_spc_reg <= '0;
            light_pos_reg <= '0;
            cam_pos_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                bpps_pkg::CFG_LIGHT_AMBIENT:   light_amb_reg <= cfg_wdata;
                bpps_pkg::CFG_LIGHT_DIFFUSE:   light_dif_reg <= cfg_wdata;
                bpps_pkg::CFG_LIGHT_SPECULAR:  light_spc_reg <= cfg_wdata;
                bpps_pkg::CFG_LIGHT_POSITION:  light_pos_reg <= cfg_wdata;
                bpps_pkg::CFG_CAMERA_POSITION: cam_pos_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // One enable for every stage: the pipeline moves unless a result is
    // waiting at the output and the sink is not taking it.
    logic ce;
    logic out_vld_reg;

    assign ce       = !out_vld_reg || m_tready;
    assign s_tready = ce;

    // Input register.
    logic [247:0] in_data_reg;
    logic         in_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (ce)
        begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            in_data_reg <= s_tdata;
        end
    end

    // Raw normal, light direction and view direction, in Q8.8 units.
    bpps_pkg::vec_t n_raw;
    bpps_pkg::vec_t l_raw;
    bpps_pkg::vec_t v_raw;
    side_t          side_in;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            n_raw[i] = COMP_W'($signed(in_data_reg[48 + POS_W*i +: POS_W]));
            l_raw[i] = COMP_W'($signed(light_pos_reg[POS_W*i +: POS_W]))
                     - COMP_W'($signed(in_data_reg[POS_W*i +: POS_W]));
            v_raw[i] = COMP_W'($signed(cam_pos_reg[POS_W*i +: POS_W]))
                     - COMP_W'($signed(in_data_reg[POS_W*i +: POS_W]));
        end
        side_in.mat_a = in_data_reg[96  +: REG_W];
        side_in.mat_d = in_data_reg[144 +: REG_W];
        side_in.mat_s = in_data_reg[192 +: REG_W];
        side_in.shin  = in_data_reg[240 +: SH_W];
    end

    bpps_pkg::vec_t n_unit;
    bpps_pkg::vec_t l_unit;
    bpps_pkg::vec_t v_unit;
    bpps_pkg::vec_t h_raw;
    bpps_pkg::vec_t h_unit;

    bpps_norm u_norm_n (.clk(clk), .ce(ce), .vec(n_raw), .unit(n_unit));
    bpps_norm u_norm_l (.clk(clk), .ce(ce), .vec(l_raw), .unit(l_unit));
    bpps_norm u_norm_v (.clk(clk), .ce(ce), .vec(v_raw), .unit(v_unit));

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            h_raw[i] = $signed(l_unit[i]) + $signed(v_unit[i]);
        end
    end

    bpps_norm u_norm_h (.clk(clk), .ce(ce), .vec(h_raw), .unit(h_unit));

    // Delay lines that keep the item's other data beside the normalizers.
    side_t   side_a_reg [0:NL-1];
    logic    vld_a_reg  [0:NL-1];
    side_b_t side_b_reg [0:NL-1];
    logic    vld_b_reg  [0:NL-1];
    side_b_t side_b_in;

    always_comb
    begin
        side_b_in.side = side_a_reg[NL-1];
        side_b_in.n    = n_unit;
        side_b_in.l    = l_unit;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            side_a_reg[0] <= side_in;
            side_b_reg[0] <= side_b_in;
            for (int k = 1; k < NL; k++)
            begin
                side_a_reg[k] <= side_a_reg[k-1];
                side_b_reg[k] <= side_b_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NL; k++)
            begin
                vld_a_reg[k] <= 1'b0;
                vld_b_reg[k] <= 1'b0;
            end
        end
        else if (ce)
        begin
            vld_a_reg[0] <= in_vld_reg;
            vld_b_reg[0] <= vld_a_reg[NL-1];
            for (int k = 1; k < NL; k++)
            begin
                vld_a_reg[k] <= vld_a_reg[k-1];
                vld_b_reg[k] <= vld_b_reg[k-1];
            end
        end
    end

    // First product stage: dot product terms and light-times-material
    // coefficients, one multiplier per term.
    logic signed [PROD_W-1:0] nl_prod_reg [3];
    logic signed [PROD_W-1:0] nh_prod_reg [3];
    logic [2:0][CH_W-1:0]     ka1_reg;
    logic [2:0][CH_W-1:0]     kd1_reg;
    logic [2:0][CH_W-1:0]     ks1_reg;
    logic [SH_W-1:0]          shin1_reg;
    logic                     vld1_reg;
    logic [2*CH_W-1:0]        ka_prod [3];
    logic [2*CH_W-1:0]        kd_prod [3];
    logic [2*CH_W-1:0]        ks_prod [3];
    side_t                    side_d;

    assign side_d = side_b_reg[NL-1].side;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            ka_prod[c] = light_amb_reg[c*CH_W +: CH_W] * side_d.mat_a[c*CH_W +: CH_W];
            kd_prod[c] = light_dif_reg[c*CH_W +: CH_W] * side_d.mat_d[c*CH_W +: CH_W];
            ks_prod[c] = light_spc_reg[c*CH_W +: CH_W] * side_d.mat_s[c*CH_W +: CH_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int i = 0; i < 3; i++)
            begin
                nl_prod_reg[i] <= $signed(side_b_reg[NL-1].n[i])
                                * $signed(side_b_reg[NL-1].l[i]);
                nh_prod_reg[i] <= $signed(side_b_reg[NL-1].n[i]) * $signed(h_unit[i]);
                ka1_reg[i]     <= ka_prod[i][2*CH_W-1 -: CH_W];
                kd1_reg[i]     <= kd_prod[i][2*CH_W-1 -: CH_W];
                ks1_reg[i]     <= ks_prod[i][2*CH_W-1 -: CH_W];
            end
            shin1_reg <= side_d.shin;
        end
    end

    // Second stage: sum the dot terms and clamp to [0, 1.0].
    logic signed [DSUM_W-1:0] ndl_sum;
    logic signed [DSUM_W-1:0] ndh_sum;
    logic [DOT_W-1:0]         ndl_clamp;
    logic [DOT_W-1:0]         ndh_clamp;
    pw_t                      pw_reg [0:SH_W];
    logic                     pw_vld_reg [0:SH_W];
    pw_t                      pw_first;

    function automatic logic [DOT_W-1:0] dot_clamp(logic signed [DSUM_W-1:0] raw);
        logic [DSUM_W-1:0] d;
        d = DSUM_W'(raw >>> FRAC_W);
        if (raw <= 0)
        begin
            return '0;
        end
        else if (d > DSUM_W'(ONE))
        begin
            return ONE;
        end
        else
        begin
            return d[DOT_W-1:0];
        end
    endfunction

    assign ndl_sum = DSUM_W'(nl_prod_reg[0]) + DSUM_W'(nl_prod_reg[1])
                   + DSUM_W'(nl_prod_reg[2]);
    assign ndh_sum = DSUM_W'(nh_prod_reg[0]) + DSUM_W'(nh_prod_reg[1])
                   + DSUM_W'(nh_prod_reg[2]);
    assign ndl_clamp = dot_clamp(ndl_sum);
    assign ndh_clamp = dot_clamp(ndh_sum);

    always_comb
    begin
        pw_first.p    = ONE;
        pw_first.b    = ndh_clamp;
        pw_first.ndl  = ndl_clamp;
        pw_first.pos  = (ndl_sum > 0);
        pw_first.ka   = ka1_reg;
        pw_first.kd   = kd1_reg;
        pw_first.ks   = ks1_reg;
        pw_first.shin = shin1_reg;
    end

    // Power by repeated squaring, one exponent bit per stage from the lowest.
    function automatic pw_t pw_step(pw_t a, int bit_idx);
        pw_t                r;
        logic [2*DOT_W-1:0] pb;
        logic [2*DOT_W-1:0] bb;
        r  = a;
        pb = a.p * a.b;
        bb = a.b * a.b;
        if (a.shin[bit_idx])
        begin
            r.p = pb[FRAC_W +: DOT_W];
        end
        r.b = bb[FRAC_W +: DOT_W];
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            pw_reg[0] <= pw_first;
            for (int k = 0; k < SH_W; k++)
            begin
                pw_reg[k+1] <= pw_step(pw_reg[k], k);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            for (int k = 0; k <= SH_W; k++)
            begin
                pw_vld_reg[k] <= 1'b0;
            end
        end
        else if (ce)
        begin
            vld1_reg      <= vld_b_reg[NL-1];
            pw_vld_reg[0] <= vld1_reg;
            for (int k = 0; k < SH_W; k++)
            begin
                pw_vld_reg[k+1] <= pw_vld_reg[k];
            end
        end
    end

    // Diffuse and specular scaling. The specular term drops out when the
    // light is behind the surface.
    logic [2:0][CH_W-1:0] ka_c_reg;
    logic [2:0][CH_W-1:0] dif_c_reg;
    logic [2:0][CH_W-1:0] spc_c_reg;
    logic                 vld_c_reg;
    logic [DOT_W-1:0]     pw_final;
    logic [CH_W+DOT_W-1:0] dif_prod [3];
    logic [CH_W+DOT_W-1:0] spc_prod [3];

    assign pw_final = pw_reg[SH_W].pos ? pw_reg[SH_W].p : '0;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            dif_prod[c] = pw_reg[SH_W].kd[c] * pw_reg[SH_W].ndl;
            spc_prod[c] = pw_reg[SH_W].ks[c] * pw_final;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int c = 0; c < 3; c++)
            begin
                ka_c_reg[c]  <= pw_reg[SH_W].ka[c];
                dif_c_reg[c] <= dif_prod[c][FRAC_W +: CH_W];
                spc_c_reg[c] <= spc_prod[c][FRAC_W +: CH_W];
            end
        end
    end

    // Channel sums with saturation, into the output register.
    logic [2:0][OUT_W-1:0] color_reg;
    logic [2:0][OUT_W-1:0] color_next;
    logic                  sat_reg;
    logic                  sat_next;
    logic [OUT_W:0]        ch_sum [3];

    always_comb
    begin
        sat_next = 1'b0;
        for (int c = 0; c < 3; c++)
        begin
            ch_sum[c] = (OUT_W+1)'(ka_c_reg[c]) + (OUT_W+1)'(dif_c_reg[c])
                      + (OUT_W+1)'(spc_c_reg[c]);
            if (ch_sum[c] > OUT_MAX)
            begin
                color_next[c] = OUT_MAX[OUT_W-1:0];
                sat_next      = 1'b1;
            end
            else
            begin
                color_next[c] = ch_sum[c][OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            color_reg <= color_next;
            sat_reg   <= sat_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_c_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (ce)
        begin
            vld_c_reg   <= pw_vld_reg[SH_W];
            out_vld_reg <= vld_c_reg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = 56'({sat_reg, color_reg[2], color_reg[1], color_reg[0]});

endmodule

@@ rtl/bpps_norm.sv @@
// Pipelined vector normalizer: squares, bit-serial square root, per-component divide.
module bpps_norm (
    input  logic           clk,
    input  logic           ce,
    input  bpps_pkg::vec_t vec,
    output bpps_pkg::vec_t unit
);

    localparam int MAG_W     = bpps_pkg::COMP_W - 1;
    localparam int SUM_W     = 2 * MAG_W;
    localparam int SCALE_SH  = 26;
    localparam int RAD_W     = SUM_W + SCALE_SH;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int REM_W     = ROOT_W + 2;
    localparam int DREM_W    = ROOT_W + 1;
    localparam int Q_W       = 18;
    localparam int DIV_SH    = 29;
    localparam int PRE_SH    = DIV_SH - Q_W;
    localparam int SQ_STEPS  = ROOT_W;
    localparam int DIV_STEPS = Q_W;

    typedef struct packed {
        logic [RAD_W-1:0]            rad;
        logic [REM_W-1:0]            rem;
        logic [ROOT_W-1:0]           root;
        logic [2:0][MAG_W-1:0]       mag;
        logic [2:0]                  neg;
        logic                        zero;
    } sq_st_t;

    typedef struct packed {
        logic [ROOT_W-1:0]           len;
        logic [2:0][DREM_W-1:0]      rem;
        logic [2:0][Q_W-1:0]         q;
        logic [2:0]                  neg;
        logic                        zero;
    } div_st_t;

    function automatic sq_st_t sq_step(sq_st_t a);
        sq_st_t           r;
        logic [REM_W-1:0] rem2;
        logic [REM_W-1:0] trial;
        r     = a;
        rem2  = {a.rem[REM_W-3:0], a.rad[RAD_W-1 -: 2]};
        trial = {a.root, 2'b01};
        if (rem2 >= trial)
        begin
            r.rem  = rem2 - trial;
            r.root = {a.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = rem2;
            r.root = {a.root[ROOT_W-2:0], 1'b0};
        end
        r.rad = {a.rad[RAD_W-3:0], 2'b00};
        return r;
    endfunction

    function automatic div_st_t div_step(div_st_t a);
        div_st_t           r;
        logic [DREM_W-1:0] r2;
        r = a;
        for (int i = 0; i < 3; i++)
        begin
            r2 = {a.rem[i][DREM_W-2:0], 1'b0};
            if (r2 >= DREM_W'(a.len))
            begin
                r.rem[i] = r2 - DREM_W'(a.len);
                r.q[i]   = {a.q[i][Q_W-2:0], 1'b1};
            end
            else
            begin
                r.rem[i] = r2;
                r.q[i]   = {a.q[i][Q_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    logic [2:0][MAG_W-1:0] mag0_reg;
    logic [2:0][MAG_W-1:0] mag0_next;
    logic [2:0]            neg0_reg;
    logic [2:0][SUM_W-1:0] sq0_reg;
    logic [SUM_W-1:0]      sum0;
    sq_st_t                sq_reg  [0:SQ_STEPS];
    sq_st_t                sq_next;
    div_st_t               div_reg [0:DIV_STEPS];
    div_st_t               div_next;
    bpps_pkg::vec_t        unit_reg;
    bpps_pkg::vec_t        unit_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag0_next[i] = vec[i][bpps_pkg::COMP_W-1]
                         ? MAG_W'(-$signed(vec[i])) : MAG_W'($signed(vec[i]));
        end
    end

    assign sum0 = sq0_reg[0] + sq0_reg[1] + sq0_reg[2];

    always_comb
    begin
        sq_next      = '0;
        sq_next.rad  = {sum0, {SCALE_SH{1'b0}}};
        sq_next.mag  = mag0_reg;
        sq_next.neg  = neg0_reg;
        sq_next.zero = (sum0 == '0);
    end

    always_comb
    begin
        div_next      = '0;
        div_next.len  = sq_reg[SQ_STEPS].root;
        div_next.neg  = sq_reg[SQ_STEPS].neg;
        div_next.zero = sq_reg[SQ_STEPS].zero;
        for (int i = 0; i < 3; i++)
        begin
            div_next.rem[i] = DREM_W'({sq_reg[SQ_STEPS].mag[i], {PRE_SH{1'b0}}});
        end
    end

    // A zero-length vector gives the zero vector.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (div_reg[DIV_STEPS].zero)
            begin
                unit_next[i] = '0;
            end
            else if (div_reg[DIV_STEPS].neg[i])
            begin
                unit_next[i] = -$signed(bpps_pkg::COMP_W'(div_reg[DIV_STEPS].q[i]));
            end
            else
            begin
                unit_next[i] = bpps_pkg::COMP_W'(div_reg[DIV_STEPS].q[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            mag0_reg <= mag0_next;
            for (int i = 0; i < 3; i++)
            begin
                neg0_reg[i] <= vec[i][bpps_pkg::COMP_W-1];
                sq0_reg[i]  <= mag0_next[i] * mag0_next[i];
            end
            sq_reg[0] <= sq_next;
            for (int k = 0; k < SQ_STEPS; k++)
            begin
                sq_reg[k+1] <= sq_step(sq_reg[k]);
            end
            div_reg[0] <= div_next;
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                div_reg[k+1] <= div_step(div_reg[k]);
            end
            unit_reg <= unit_next;
        end
    end

    assign unit = unit_reg;

endmodule
